/* sv/epr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_pkg
// Shared constants, codes and types of the echo pulse ranging block.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int DISTANCE_WIDTH   = 24;
  localparam int MAX_KEPT_SAMPLES = 255;

  localparam int TIME_W    = 64;
  localparam int FRAC_W    = 6;
  localparam int TOTAL_W   = 40;
  localparam int CPC_W     = 32;
  localparam int SAMPLES_W = 8;
  localparam int COUNT_W   = 9;
  localparam int MK_W      = 10;
  localparam int DVD_W     = TIME_W + FRAC_W;
  localparam int STEP_W    = $clog2(DVD_W + 1);
  localparam int PAD_W     = DVD_W - TOTAL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CPC_W-1:0]     CPC_RESET     = 32'd23200;
  localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLES_PER_CM = 2'd0,
    REG_SAMPLES_M     = 2'd1
  } reg_idx_t;

  typedef enum logic {
    OP_EDGE    = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_ACCUM,
    ST_CHECK,
    ST_AVG,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

/* sv/epr_echo_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_echo_if
// Request channel carrying echo edge events and restart commands.
// ----------------------------------------------------------------------------
interface epr_echo_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [epr_pkg::TIME_W-1:0]  edge_time;

  modport source (output valid, opcode, edge_time, input ready);
  modport sink   (input valid, opcode, edge_time, output ready);
endinterface

/* sv/epr_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_result_if
// Result channel carrying one measured distance and the batch average.
// ----------------------------------------------------------------------------
interface epr_result_if #(
  parameter int DW = epr_pkg::DISTANCE_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [DW-1:0]               distance_q6;
  logic [epr_pkg::TIME_W-1:0]  end_time;
  logic                        batch_done;
  logic [DW-1:0]               average_q6;

  modport source (output valid, distance_q6, end_time, batch_done, average_q6,
                  input ready);
  modport sink   (input valid, distance_q6, end_time, batch_done, average_q6,
                  output ready);
endinterface

/* sv/epr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_div
// Shared restoring divider, one quotient bit per cycle, saturation flag.
// ----------------------------------------------------------------------------
module epr_div #(
  parameter int QW = epr_pkg::DISTANCE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  epr_pkg::div_ctl_t           ctl,
  input  logic [epr_pkg::DVD_W-1:0]   dividend,
  input  logic [epr_pkg::CPC_W-1:0]   divisor,
  output logic [QW-1:0]               quotient,
  output epr_pkg::div_stat_t          stat
);

  logic [epr_pkg::DVD_W-1:0]  dvd;
  logic [epr_pkg::CPC_W-1:0]  dsr;
  logic [epr_pkg::CPC_W-1:0]  rem;
  logic [epr_pkg::CPC_W-1:0]  rem_next;
  logic [epr_pkg::CPC_W:0]    rem_sh;
  logic [epr_pkg::CPC_W:0]    rem_dif;
  logic                       fits;
  logic [QW-1:0]              quo;
  logic                       sat;
  logic [epr_pkg::STEP_W-1:0] cnt;
  logic                       busy;
  logic                       done;

  // bring down the next dividend bit and try a subtract
  assign rem_sh   = {rem, dvd[epr_pkg::DVD_W-1]};
  assign rem_dif  = rem_sh - {1'b0, dsr};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign rem_next = fits ? rem_dif[epr_pkg::CPC_W-1:0] : rem_sh[epr_pkg::CPC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == epr_pkg::STEP_W'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - epr_pkg::STEP_W'(1);
        if (cnt == epr_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[epr_pkg::DVD_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[QW-2:0], fits};
      // a one shifted out of the top means the quotient is too wide
      sat <= sat | quo[QW-1];
    end
  end

  assign quotient  = quo;
  assign stat.done = done;
  assign stat.sat  = sat;

`ifndef ASSERT_OFF
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("divider busy with zero step count");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy)
    else $error("divider started while busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (busy && (cnt == epr_pkg::STEP_W'(1)) && !ctl.start) |=> (stat.done && !busy))
    else $error("divider did not finish after last step");
`endif

endmodule

/* sv/epr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epr_seq
// Sequencer: edge phase, batch statistics, divider control, result register.
// ----------------------------------------------------------------------------
module epr_seq #(
  parameter int DISTANCE_WIDTH   = epr_pkg::DISTANCE_WIDTH,
  parameter int MAX_KEPT_SAMPLES = epr_pkg::MAX_KEPT_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [epr_pkg::CPC_W-1:0]       cycles_per_cm,
  input  logic [epr_pkg::SAMPLES_W-1:0]   samples_m,
  epr_echo_if.sink                        echo,
  epr_result_if.source                    result,
  output epr_pkg::div_ctl_t               div_ctl,
  output logic [epr_pkg::DVD_W-1:0]       div_dividend,
  output logic [epr_pkg::CPC_W-1:0]       div_divisor,
  input  logic [DISTANCE_WIDTH-1:0]       div_quotient,
  input  epr_pkg::div_stat_t              div_stat
);

  localparam int DW = DISTANCE_WIDTH;

  epr_pkg::state_t state, state_next;

  logic                             edge_pending;
  logic [epr_pkg::TIME_W-1:0]       start_time;
  logic [epr_pkg::TIME_W-1:0]       end_time;
  logic [epr_pkg::TOTAL_W-1:0]      total;
  logic [DW-1:0]                    dmin;
  logic [DW-1:0]                    dmax;
  logic [epr_pkg::COUNT_W-1:0]      count;
  logic [DW-1:0]                    meas;
  logic [DW-1:0]                    avg;
  logic                             bdone;

  logic                             out_valid;
  logic [DW-1:0]                    out_dist;
  logic [epr_pkg::TIME_W-1:0]       out_time;
  logic                             out_done;
  logic [DW-1:0]                    out_avg;

  logic                             accept;
  logic                             is_restart;
  logic                             load_out;
  logic [epr_pkg::SAMPLES_W-1:0]    m_eff;
  logic                             batch_hit;
  logic [epr_pkg::TOTAL_W-1:0]      trimmed;
  logic [epr_pkg::TIME_W-1:0]       elapsed;
  logic [DW-1:0]                    q_sat;

  assign echo.ready = (state == epr_pkg::ST_IDLE);
  assign accept     = echo.valid && echo.ready;
  assign is_restart = (epr_pkg::opcode_t'(echo.opcode) == epr_pkg::OP_RESTART);
  assign load_out   = (state == epr_pkg::ST_EMIT) && (!out_valid || result.ready);

  // kept-sample count clamps to the configured maximum
  assign m_eff = ({2'b00, samples_m} > epr_pkg::MK_W'(MAX_KEPT_SAMPLES))
               ? epr_pkg::SAMPLES_W'(MAX_KEPT_SAMPLES) : samples_m;
  assign batch_hit = (count >= (epr_pkg::COUNT_W'(m_eff) + epr_pkg::COUNT_W'(2)));
  assign trimmed   = total - epr_pkg::TOTAL_W'(dmin) - epr_pkg::TOTAL_W'(dmax);
  assign elapsed   = echo.edge_time - start_time;
  assign q_sat     = div_stat.sat ? '1 : div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_ctl.start = 1'b0;
    div_ctl.steps = epr_pkg::STEP_W'(epr_pkg::DVD_W);
    div_dividend  = {elapsed, {epr_pkg::FRAC_W{1'b0}}};
    div_divisor   = cycles_per_cm;
    unique case (state)
      epr_pkg::ST_IDLE: begin
        if (accept && !is_restart && edge_pending) begin
          div_ctl.start = 1'b1;
          state_next    = epr_pkg::ST_DIST;
        end
      end
      epr_pkg::ST_DIST: begin
        if (div_stat.done) begin
          state_next = epr_pkg::ST_ACCUM;
        end
      end
      epr_pkg::ST_ACCUM: begin
        state_next = epr_pkg::ST_CHECK;
      end
      epr_pkg::ST_CHECK: begin
        div_ctl.steps = epr_pkg::STEP_W'(epr_pkg::TOTAL_W);
        div_dividend  = {trimmed, {epr_pkg::PAD_W{1'b0}}};
        div_divisor   = epr_pkg::CPC_W'(m_eff);
        if (batch_hit && (m_eff != '0)) begin
          div_ctl.start = 1'b1;
          state_next    = epr_pkg::ST_AVG;
        end else begin
          state_next = epr_pkg::ST_EMIT;
        end
      end
      epr_pkg::ST_AVG: begin
        if (div_stat.done) begin
          state_next = epr_pkg::ST_EMIT;
        end
      end
      epr_pkg::ST_EMIT: begin
        if (load_out) begin
          state_next = epr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = epr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_pending <= 1'b0;
      start_time   <= '0;
      total        <= '0;
      dmin         <= '1;
      dmax         <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        epr_pkg::ST_IDLE: begin
          if (accept) begin
            if (is_restart) begin
              edge_pending <= 1'b0;
              start_time   <= '0;
              total        <= '0;
              dmin         <= '1;
              dmax         <= '0;
              count        <= '0;
            end else if (!edge_pending) begin
              edge_pending <= 1'b1;
              start_time   <= echo.edge_time;
            end else begin
              edge_pending <= 1'b0;
            end
          end
        end
        epr_pkg::ST_ACCUM: begin
          total <= total + epr_pkg::TOTAL_W'(meas);
          if (meas < dmin) begin
            dmin <= meas;
          end
          if (meas > dmax) begin
            dmax <= meas;
          end
          count <= count + epr_pkg::COUNT_W'(1);
        end
        epr_pkg::ST_CHECK: begin
          if (batch_hit) begin
            total <= '0;
            dmin  <= '1;
            dmax  <= '0;
            count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      end_time <= echo.edge_time;
    end
    if ((state == epr_pkg::ST_DIST) && div_stat.done) begin
      meas <= q_sat;
    end
    if (state == epr_pkg::ST_CHECK) begin
      bdone <= batch_hit;
      avg   <= '0;
    end
    if ((state == epr_pkg::ST_AVG) && div_stat.done) begin
      avg <= q_sat;
    end
    if (load_out) begin
      out_dist <= meas;
      out_time <= end_time;
      out_done <= bdone;
      out_avg  <= avg;
    end
  end

  assign result.valid       = out_valid;
  assign result.distance_q6 = out_dist;
  assign result.end_time    = out_time;
  assign result.batch_done  = out_done;
  assign result.average_q6  = out_avg;

`ifndef ASSERT_OFF
  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == epr_pkg::ST_CHECK) && batch_hit) |=> (count == '0))
    else $error("batch not cleared after completion");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (dmin <= dmax))
    else $error("batch minimum above maximum");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == epr_pkg::ST_EMIT) && out_valid && !result.ready)
      |=> (out_valid && (state == epr_pkg::ST_EMIT)))
    else $error("pending result overwritten");
`endif

endmodule

/* sv/echo_pulse_ranging_trimmed_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_ranging_trimmed_mean
// Echo pulse-width ranger with a batch trimmed-mean average.
// ----------------------------------------------------------------------------
// Usage:
//   echo request: opcode 0 is an echo edge stamped with edge_time, opcode 1
//   restarts the batch and the edge phase. Edges alternate opening and
//   closing a pulse; each closing edge gives one result request with the
//   Q6 distance, the closing time and, on the last sample of a batch, the
//   trimmed mean of the batch.
//   wr_en / wr_index / wr_data write cycles_per_cm (0) and samples_m (1);
//   the user must write them only while the block is idle (not enforced).
// Sequence:
//   a closing edge runs the shared restoring divider for 70 steps (one
//   quotient bit per cycle); a batch-ending edge adds a 40-step average
//   division unless the kept-sample count is zero. One request is worked
//   on at a time; echo.ready is high only between requests.
// Reset clears the edge phase, the batch and the configuration to its
// defaults. A stalled result holds in the output register; the next echo
// request is still taken, and a new result waits until the slot frees.
// ----------------------------------------------------------------------------
module echo_pulse_ranging_trimmed_mean #(
  parameter int DISTANCE_WIDTH   = epr_pkg::DISTANCE_WIDTH,
  parameter int MAX_KEPT_SAMPLES = epr_pkg::MAX_KEPT_SAMPLES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [epr_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [epr_pkg::CFG_DATA_W-1:0]   wr_data,
  epr_echo_if.sink                         echo,
  epr_result_if.source                     result
);

  logic [epr_pkg::CPC_W-1:0]       cycles_per_cm;
  logic [epr_pkg::SAMPLES_W-1:0]   samples_m;

  epr_pkg::div_ctl_t               div_ctl;
  epr_pkg::div_stat_t              div_stat;
  logic [epr_pkg::DVD_W-1:0]       div_dividend;
  logic [epr_pkg::CPC_W-1:0]       div_divisor;
  logic [DISTANCE_WIDTH-1:0]       div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_cm <= epr_pkg::CPC_RESET;
      samples_m     <= epr_pkg::SAMPLES_RESET;
    end else if (wr_en) begin
      unique case (epr_pkg::reg_idx_t'(wr_index))
        epr_pkg::REG_CYCLES_PER_CM: cycles_per_cm <= wr_data[epr_pkg::CPC_W-1:0];
        epr_pkg::REG_SAMPLES_M:     samples_m     <= wr_data[epr_pkg::SAMPLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  epr_seq #(
    .DISTANCE_WIDTH   (DISTANCE_WIDTH),
    .MAX_KEPT_SAMPLES (MAX_KEPT_SAMPLES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cycles_per_cm (cycles_per_cm),
    .samples_m     (samples_m),
    .echo          (echo),
    .result        (result),
    .div_ctl       (div_ctl),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_quotient  (div_quotient),
    .div_stat      (div_stat)
  );

  epr_div #(
    .QW (DISTANCE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

endmodule

/* sim/tb_echo_pulse_ranging_trimmed_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_pulse_ranging_trimmed_mean
// Self-checking bench for the echo pulse ranger. A behavioral predictor
// tracks the edge phase, the batch statistics and both registers, and
// queues one expected measurement per closing edge. Every result request
// is compared field by field against that queue. Directed pulses cover the
// special cases. Random traffic then runs under several register settings
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_echo_pulse_ranging_trimmed_mean;

  localparam int DW            = epr_pkg::DISTANCE_WIDTH;
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [63:0] DIST_MAX = (64'd1 << DW) - 64'd1;

  typedef struct packed {
    logic [DW-1:0]              distance_q6;
    logic [epr_pkg::TIME_W-1:0] end_time;
    logic                       batch_done;
    logic [DW-1:0]              average_q6;
  } measurement_t;

  logic                           clk;
  logic                           rst;
  logic                           wr_en;
  logic [epr_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [epr_pkg::CFG_DATA_W-1:0] wr_data;

  epr_echo_if   echo_ch ();
  epr_result_if result_ch ();

  echo_pulse_ranging_trimmed_mean u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .echo     (echo_ch),
    .result   (result_ch)
  );

  // predictor state and register copies
  logic                          open_pending;
  logic [epr_pkg::TIME_W-1:0]    open_time;
  logic [epr_pkg::TOTAL_W-1:0]   batch_total;
  logic [DW-1:0]                 batch_min;
  logic [DW-1:0]                 batch_max;
  int                            batch_count;
  logic [epr_pkg::CPC_W-1:0]     ticks_per_cm;
  logic [epr_pkg::SAMPLES_W-1:0] kept_samples;

  measurement_t expected_measurements[$];

  bit gaps_on;
  int n_requests;
  int n_results;
  int n_batches;
  int n_errors;
  int stall_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_batch();
    batch_total = '0;
    batch_min   = '1;
    batch_max   = '0;
    batch_count = 0;
  endfunction

  // elapsed * 64 / divisor at full width, saturated to the distance width
  function automatic logic [DW-1:0] q6_range(input logic [63:0] elapsed,
                                             input logic [epr_pkg::CPC_W-1:0] divisor);
    logic [63:0] div64;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] q;
    if (divisor == '0) return DIST_MAX[DW-1:0];
    div64 = 64'(divisor);
    whole = elapsed / div64;
    rem   = elapsed % div64;
    if (whole > DIST_MAX) return DIST_MAX[DW-1:0];
    q = (whole << epr_pkg::FRAC_W) + ((rem << epr_pkg::FRAC_W) / div64);
    return (q > DIST_MAX) ? DIST_MAX[DW-1:0] : q[DW-1:0];
  endfunction

  function automatic void predict_echo(input epr_pkg::opcode_t op,
                                       input logic [63:0] stamp);
    measurement_t m;
    logic [epr_pkg::TOTAL_W-1:0] trimmed;
    logic [epr_pkg::TOTAL_W-1:0] avg;
    int keep;
    if (op == epr_pkg::OP_RESTART) begin
      open_pending = 1'b0;
      open_time    = '0;
      reset_batch();
      return;
    end
    if (!open_pending) begin
      open_pending = 1'b1;
      open_time    = stamp;
      return;
    end
    open_pending  = 1'b0;
    m.distance_q6 = q6_range(stamp - open_time, ticks_per_cm);
    m.end_time    = stamp;
    m.batch_done  = 1'b0;
    m.average_q6  = '0;
    batch_total   = batch_total + epr_pkg::TOTAL_W'(m.distance_q6);
    if (m.distance_q6 < batch_min) batch_min = m.distance_q6;
    if (m.distance_q6 > batch_max) batch_max = m.distance_q6;
    batch_count++;
    keep = (int'(kept_samples) > epr_pkg::MAX_KEPT_SAMPLES) ?
           epr_pkg::MAX_KEPT_SAMPLES : int'(kept_samples);
    if (batch_count >= keep + 2) begin
      m.batch_done = 1'b1;
      if (keep != 0) begin
        trimmed = batch_total - epr_pkg::TOTAL_W'(batch_min) -
                  epr_pkg::TOTAL_W'(batch_max);
        avg     = trimmed / epr_pkg::TOTAL_W'(keep);
        m.average_q6 = (64'(avg) > DIST_MAX) ? DIST_MAX[DW-1:0] : avg[DW-1:0];
      end
      reset_batch();
    end
    expected_measurements.push_back(m);
  endfunction

  task automatic send_echo(input epr_pkg::opcode_t op, input logic [63:0] stamp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      echo_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    echo_ch.valid     <= 1'b1;
    echo_ch.opcode    <= op;
    echo_ch.edge_time <= stamp;
    do @(posedge clk); while (!echo_ch.ready);
    predict_echo(op, stamp);
    n_requests++;
  endtask

  task automatic pulse(input logic [63:0] opened, input logic [63:0] elapsed);
    send_echo(epr_pkg::OP_EDGE, opened);
    send_echo(epr_pkg::OP_EDGE, opened + elapsed);
  endtask

  // sender holds off until every measurement has come back
  task automatic wait_results();
    @(negedge clk);
    echo_ch.valid <= 1'b0;
    while (expected_measurements.size() != 0) @(posedge clk);
  endtask

  // opening edges and restarts give no result, so let the block settle too
  task automatic idle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers change only once no measurement is still being worked on
  task automatic write_reg(input epr_pkg::reg_idx_t idx,
                           input logic [epr_pkg::CFG_DATA_W-1:0] value);
    wait_results();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    case (idx)
      epr_pkg::REG_CYCLES_PER_CM: ticks_per_cm = value[epr_pkg::CPC_W-1:0];
      epr_pkg::REG_SAMPLES_M:     kept_samples = value[epr_pkg::SAMPLES_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] draw_elapsed(input logic [epr_pkg::CPC_W-1:0] cpc);
    case ($urandom_range(0, 7))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 3));
      default: return 64'(cpc) * 64'($urandom_range(0, 1 << 18)) +
                      64'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic test_default_ranging();
    pulse(64'd0, 64'd23200);
    // counter wraps between the opening and the closing edge
    pulse(64'hFFFF_FFFF_FFFF_FF00, 64'd46417);
    send_echo(epr_pkg::OP_RESTART, '1);
    // restart while a pulse is open
    send_echo(epr_pkg::OP_EDGE, 64'd500);
    send_echo(epr_pkg::OP_RESTART, 64'h1234_5678_9ABC_DEF0);
    pulse(64'd777, 64'd0);
    pulse({$urandom, $urandom}, 64'd81200);
    pulse(64'd0, 64'd23200 * 64'd400);
  endtask

  task automatic test_divisor_extremes();
    idle_block();
    write_reg(epr_pkg::REG_CYCLES_PER_CM, 32'd0);
    pulse(64'd42, 64'd5);
    write_reg(epr_pkg::REG_CYCLES_PER_CM, 32'd1);
    pulse(64'd0, '1);
    write_reg(epr_pkg::REG_CYCLES_PER_CM, 32'hFFFF_FFFF);
    pulse(64'd1, 64'hFFFF_FFFF * 64'd1000 + 64'd7);
  endtask

  task automatic test_samples_extremes();
    idle_block();
    write_reg(epr_pkg::REG_SAMPLES_M, 32'd5);
    pulse(64'd10, 64'hFFFF_FFFF * 64'd3);
    // lowering the count mid-batch closes the batch on the next sample
    idle_block();
    write_reg(epr_pkg::REG_SAMPLES_M, 32'd0);
    pulse(64'd20, 64'hFFFF_FFFF * 64'd9);
    pulse({$urandom, $urandom}, 64'hFFFF_FFFF * 64'd2);
    pulse({$urandom, $urandom}, 64'hFFFF_FFFF * 64'd70000);
  endtask

  task automatic random_phase(input logic [epr_pkg::CPC_W-1:0] cpc,
                              input logic [epr_pkg::SAMPLES_W-1:0] keep,
                              input int n_items, input bit pairs_only);
    int sent;
    logic [63:0] opened;
    idle_block();
    write_reg(epr_pkg::REG_CYCLES_PER_CM, cpc);
    write_reg(epr_pkg::REG_SAMPLES_M, epr_pkg::CFG_DATA_W'(keep));
    sent = 0;
    if (pairs_only) begin
      send_echo(epr_pkg::OP_RESTART, {$urandom, $urandom});
      sent++;
    end
    while (sent < n_items) begin
      if (!pairs_only && $urandom_range(0, 99) < 15) begin
        // stray restart or lone edge that shifts the edge phase
        send_echo($urandom_range(0, 1) ? epr_pkg::OP_RESTART : epr_pkg::OP_EDGE,
                  {$urandom, $urandom});
        sent++;
      end else begin
        opened = ($urandom_range(0, 4) == 0) ?
                 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100000)) :
                 {$urandom, $urandom};
        pulse(opened, draw_elapsed(cpc));
        sent += 2;
      end
      if ($urandom_range(0, 39) == 0) wait_results();
      if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
    end
  endtask

  task automatic test_random_traffic();
    random_phase(epr_pkg::CPC_RESET, epr_pkg::SAMPLES_RESET, 8, 1'b0);
    random_phase(32'd1, 8'd0, 6, 1'b0);
    random_phase(32'hFFFF_FFFF, 8'd4, 6, 1'b0);
    random_phase(32'd0, 8'd3, 6, 1'b0);
    random_phase(epr_pkg::CPC_W'($urandom_range(1, 100000)),
                 epr_pkg::SAMPLES_W'($urandom_range(2, 20)), 8, 1'b0);
    // one full batch at the largest sample count
    random_phase(epr_pkg::CPC_W'($urandom_range(20, 2000)), 8'd255, 515, 1'b1);
  endtask

  // result side: random stall before each request
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    measurement_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      n_results++;
      if (expected_measurements.size() == 0) begin
        $error("result with no measurement waiting: distance_q6 %0h end_time %0h",
               result_ch.distance_q6, result_ch.end_time);
        n_errors++;
      end else begin
        want = expected_measurements.pop_front();
        if (result_ch.distance_q6 !== want.distance_q6) begin
          $error("distance_q6 expected %0h actual %0h", want.distance_q6,
                 result_ch.distance_q6);
          n_errors++;
        end
        if (result_ch.end_time !== want.end_time) begin
          $error("end_time expected %0h actual %0h", want.end_time, result_ch.end_time);
          n_errors++;
        end
        if (result_ch.batch_done !== want.batch_done) begin
          $error("batch_done expected %0b actual %0b", want.batch_done,
                 result_ch.batch_done);
          n_errors++;
        end
        if (result_ch.average_q6 !== want.average_q6) begin
          $error("average_q6 expected %0h actual %0h", want.average_q6,
                 result_ch.average_q6);
          n_errors++;
        end
        if (want.batch_done) n_batches++;
      end
    end
  end

  // watchdog on cycles with no request moving on either channel
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (echo_ch.valid && echo_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb_echo_pulse_ranging_trimmed_mean: done, errors");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = epr_pkg::REG_CYCLES_PER_CM;
    wr_data           = '0;
    echo_ch.valid     = 1'b0;
    echo_ch.opcode    = epr_pkg::OP_EDGE;
    echo_ch.edge_time = '0;
    gaps_on           = 1'b1;
    n_requests        = 0;
    n_results         = 0;
    n_batches         = 0;
    n_errors          = 0;
    open_pending      = 1'b0;
    open_time         = '0;
    ticks_per_cm      = epr_pkg::CPC_RESET;
    kept_samples      = epr_pkg::SAMPLES_RESET;
    reset_batch();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_ranging();
    test_divisor_extremes();
    test_samples_extremes();
    test_random_traffic();
    idle_block();

    $display("covered %0d echo requests, %0d distances checked, %0d batches closed",
             n_requests, n_results, n_batches);
    $display("divisor from zero to all ones, kept samples from 0 to 255, counter wrap");
    if (n_errors == 0)
      $display("tb_echo_pulse_ranging_trimmed_mean: done, clean");
    else
      $display("tb_echo_pulse_ranging_trimmed_mean: done, errors");
    $finish;
  end

endmodule
